[hw/rtl/rm_pkg.sv]
`timescale 1ns / 1ps

package rm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int SCOUNT_W = 7;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } rm_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] median;
    logic        [SCOUNT_W-1:0] sample_count;
    logic                       overflow;
  } rm_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch input transaction, pos <= count
    logic rd_shift;   // read entry pos-1
    logic wr_shift;   // move read entry up to pos, pos--
    logic wr_sample;  // write sample at pos, count++
    logic rd_med;     // read middle pair
    logic ld_out;     // load result register
  } rm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_one;
    logic gt;
  } rm_sts_t;

endpackage

[hw/rtl/running_median.sv]
`timescale 1ns / 1ps

// channel | direction | handshake              | payload
// in_     | input     | in_valid / in_ready    | rm_in_t  {sample, last_sample}
// out_    | output    | out_valid / out_ready  | rm_out_t {median, sample_count, overflow}
//
// Per transaction, accept to accept: a sample dropped on a full store goes straight
// to the median read; else each held sample greater than it takes one read and one
// compare/write step, plus a read and a compare if it stops above the bottom entry.
// Reset: rst_n low empties the store count; store contents stay undefined.
// Stalls: a finished result waits in the output register while a new input
// transaction is taken; the sequencer waits only if the next result is ready first.

module running_median #(
  parameter int CAPACITY = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rm_pkg::rm_in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rm_pkg::rm_out_t out_data
);
  import rm_pkg::*;

  rm_cmd_t cmd;
  rm_sts_t sts;
  logic    in_fire;

  assign in_fire = in_valid & in_ready;

  // sequencer: accept, shift loop, insert, median read, result load
  rm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // sorted store, count, pointers, median arithmetic, result register
  rm_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // the store has one write port
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_shift, cmd.wr_sample}))
    else $error("two store writes in one cycle");

  // an accepted transaction takes the sequencer out of idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input taken twice back to back");

  // a dropped sample is only reported against a full store
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> out_data.sample_count == SCOUNT_W'(CAPACITY))
    else $error("drop reported below capacity");

  // a median read is always followed by the result stage, not by a new input
  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_med |=> !cmd.load && !in_ready)
    else $error("median read not followed by result stage");

endmodule

[hw/rtl/rm_ctrl.sv]
`timescale 1ns / 1ps

module rm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  rm_pkg::rm_sts_t sts,
  output rm_pkg::rm_cmd_t cmd
);
  import rm_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_RD       = 6'b000010,
    ST_CMP      = 6'b000100,
    ST_WRITE    = 6'b001000,
    ST_MED_RD   = 6'b010000,
    ST_MED_CALC = 6'b100000
  } rm_state_t;

  rm_state_t state_r, state_nxt;
  logic      out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.full) begin
            state_nxt = ST_MED_RD;
          end else if (sts.empty) begin
            state_nxt = ST_WRITE;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd.rd_shift = 1'b1;
        state_nxt    = ST_CMP;
      end
      ST_CMP: begin
        if (sts.gt) begin
          cmd.wr_shift = 1'b1;
          state_nxt    = sts.pos_one ? ST_WRITE : ST_RD;
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.wr_sample = 1'b1;
        state_nxt     = ST_MED_RD;
      end
      ST_MED_RD: begin
        cmd.rd_med = 1'b1;
        state_nxt  = ST_MED_CALC;
      end
      ST_MED_CALC: begin
        if (!out_valid_r || out_ready) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hw/rtl/rm_datapath.sv]
`timescale 1ns / 1ps

module rm_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rm_pkg::rm_in_t  in_data,
  input  rm_pkg::rm_cmd_t cmd,
  output rm_pkg::rm_sts_t sts,
  output rm_pkg::rm_out_t out_data
);
  import rm_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [SAMPLE_W-1:0] mem [CAPACITY];

  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       last_r;
  logic                       drop_r;
  logic        [AW-1:0]       pos_r;
  logic        [CW-1:0]       cnt_r, cnt_nxt;
  logic signed [SAMPLE_W-1:0] rd_a_r, rd_b_r;
  rm_out_t                    out_r;

  logic        [CW-1:0]       cnt_m1, cnt_half;
  logic        [AW-1:0]       addr_a, addr_lo, addr_hi;
  logic                       wr_en;
  logic signed [SAMPLE_W-1:0] wr_data;
  logic signed [SAMPLE_W:0]   pair_sum, pair_adj;
  logic signed [SAMPLE_W-1:0] median;
  logic        [CW+SCOUNT_W-1:0] cnt_ext;

  // middle pair: lo = (n-1)/2, hi = n/2; equal for odd n
  assign cnt_m1   = cnt_r - CW'(1);
  assign cnt_half = cnt_r >> 1;
  assign addr_lo  = AW'(cnt_m1 >> 1);
  assign addr_hi  = AW'(cnt_half);
  assign addr_a   = cmd.rd_shift ? (pos_r - AW'(1)) : addr_lo;

  assign wr_en   = cmd.wr_shift | cmd.wr_sample;
  assign wr_data = cmd.wr_shift ? rd_a_r : sample_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r] <= wr_data;
    end
    if (cmd.rd_shift || cmd.rd_med) begin
      rd_a_r <= mem[addr_a];
    end
    if (cmd.rd_med) begin
      rd_b_r <= mem[addr_hi];
    end
  end

  // even count: 33-bit sum, halved toward zero
  assign pair_sum = {rd_a_r[SAMPLE_W-1], rd_a_r} + {rd_b_r[SAMPLE_W-1], rd_b_r};
  assign pair_adj = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};
  assign median   = cnt_r[0] ? rd_a_r : pair_adj[SAMPLE_W:1];

  assign cnt_ext = (CW + SCOUNT_W)'(cnt_r);

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.wr_sample) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.ld_out && last_r) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_data.sample;
      last_r   <= in_data.last_sample;
      drop_r   <= sts.full;
      pos_r    <= AW'(cnt_r);
    end else if (cmd.wr_shift) begin
      pos_r <= pos_r - AW'(1);
    end
    if (cmd.ld_out) begin
      out_r.median       <= median;
      out_r.sample_count <= cnt_ext[SCOUNT_W-1:0];
      out_r.overflow     <= drop_r;
    end
  end

  assign sts.full    = (cnt_r == CW'(CAPACITY));
  assign sts.empty   = (cnt_r == '0);
  assign sts.pos_one = (pos_r == AW'(1));
  assign sts.gt      = (rd_a_r > sample_r);

  assign out_data = out_r;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import rm_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int S_MIN        = 32'sh8000_0000;
  localparam int S_MAX        = 32'sh7fff_ffff;
  // worst case is a transaction that shifts the whole store; leave margin
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int PHASE_ITEMS  = 275;

  // sample patterns for the random sequences
  typedef enum int {MIX_FULL, MIX_NARROW, MIX_EXTREME, MIX_FALLING} mix_t;

  // per-transaction note from the driver: fixed result typed in by hand, or not
  typedef struct {
    bit      fixed;
    rm_out_t res;
  } typed_t;

  // directed row: stimulus, plus the hand result where it is obvious
  typedef struct {
    int sample;
    bit last;
    bit fixed;
    int med;
    int cnt;
    bit ovf;
  } row_t;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_ready;
  rm_in_t  in_data   = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  rm_out_t out_data;

  int idle_pct  = 0;  // sender: chance per cycle of a gap after a transaction
  int stall_pct = 0;  // receiver: chance per cycle of out_ready low
  int err_cnt   = 0;
  int cycles    = 0;
  int items_sent  = 0;
  int results_seen = 0;
  int drops_seen  = 0;
  int seq_cnt     = 0;

  logic signed [31:0] sorted_samples[$];   // predictor copy of the store
  rm_out_t            pending_medians[$];  // expected results, oldest first
  typed_t             typed_q[$];          // one entry per driven transaction

  // Directed part. Hand results cover the easy rows: single samples, pairs,
  // extremes and the truncation toward zero of odd pair sums. The rest are
  // left to the predictor (duplicates, inserts landing mid-store).
  row_t dir_rows [0:21] = '{
    '{5,       0, 1, 5,     1, 0},
    '{7,       0, 1, 6,     2, 0},
    '{S_MIN,   1, 1, 5,     3, 0},  // odd count, ends the sequence
    '{S_MAX,   0, 1, S_MAX, 1, 0},
    '{S_MAX,   0, 1, S_MAX, 2, 0},  // pair sum needs the 33rd bit
    '{S_MIN,   0, 1, S_MAX, 3, 0},
    '{S_MIN,   1, 1, 0,     4, 0},  // (min + max) / 2 = -1 / 2 -> 0
    '{-3,      0, 1, -3,    1, 0},
    '{-4,      1, 1, -3,    2, 0},  // -7 / 2 -> -3, not -4
    '{-1,      0, 1, -1,    1, 0},
    '{2,       1, 1, 0,     2, 0},  // 1 / 2 -> 0
    '{S_MIN,   0, 1, S_MIN, 1, 0},
    '{S_MIN,   1, 1, S_MIN, 2, 0},  // most negative pair sum
    '{0,       1, 1, 0,     1, 0},  // one-sample sequence
    '{100,     0, 0, 0,     0, 0},
    '{-50,     0, 0, 0,     0, 0},
    '{100,     0, 0, 0,     0, 0},
    '{25,      0, 0, 0,     0, 0},
    '{-50,     0, 0, 0,     0, 0},
    '{32'sh1234_5678, 0, 0, 0, 0, 0},
    '{32'shedcb_a988, 0, 0, 0, 0, 0},
    '{0,       1, 0, 0,     0, 0}
  };

  running_median #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Predictor: sorted insert, then median of what is held. A full store
  // drops the sample and keeps the old median. The last mark empties the
  // store only after the result is formed.
  function automatic rm_out_t predict_median(input rm_in_t t);
    rm_out_t r;
    int      pos;
    int      n;
    longint  pair_sum;
    r = '0;
    n = sorted_samples.size();
    if (n >= CAPACITY) begin
      r.overflow = 1'b1;
    end else begin
      pos = n;
      while (pos > 0 && sorted_samples[pos-1] > $signed(t.sample)) pos--;
      sorted_samples.insert(pos, t.sample);
      n++;
    end
    if (n == 0) begin
      r.median = '0;
    end else if (n % 2) begin
      r.median = sorted_samples[n/2];
    end else begin
      // 64-bit sum, so min+min and max+max stay exact; '/' truncates to zero
      pair_sum = longint'(sorted_samples[n/2-1]) + longint'(sorted_samples[n/2]);
      r.median = 32'(pair_sum / 2);
    end
    r.sample_count = 7'(n);
    if (t.last_sample) sorted_samples.delete();
    return r;
  endfunction

  // Input side: every accepted transaction gets its expectation here,
  // from the hand-typed row if there is one, else from the predictor.
  always @(posedge clk) begin : watch_in
    rm_out_t want;
    typed_t  note;
    if (rst_n && in_valid && in_ready) begin
      want = predict_median(in_data);
      note = typed_q.pop_front();
      if (note.fixed) want = note.res;
      if (want.overflow) drops_seen++;
      pending_medians.push_back(want);
    end
  end

  // Receiver: random back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // Output side: compare field by field with the oldest expectation.
  always @(posedge clk) begin : watch_out
    rm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_medians.size() == 0) begin
        err_cnt++;
        $error("unexpected result: median %0d, sample_count %0d, overflow %0b",
               $signed(out_data.median), out_data.sample_count, out_data.overflow);
      end else begin
        want = pending_medians.pop_front();
        if (out_data.median !== want.median) begin
          err_cnt++;
          $error("median: expected %0d, got %0d",
                 $signed(want.median), $signed(out_data.median));
        end
        if (out_data.sample_count !== want.sample_count) begin
          err_cnt++;
          $error("sample_count: expected %0d, got %0d",
                 want.sample_count, out_data.sample_count);
        end
        if (out_data.overflow !== want.overflow) begin
          err_cnt++;
          $error("overflow: expected %0b, got %0b", want.overflow, out_data.overflow);
        end
      end
    end
  end

  // Drive one transaction and hold it until taken, then maybe leave a gap.
  // Called at a rising edge; all drives are nonblocking.
  task automatic push_sample(input rm_in_t t, input bit fixed, input rm_out_t res);
    typed_q.push_back('{fixed, res});
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Random sequences. Most are short; about one in five comes near or runs past the
  // store size so that drops and a last mark on a full store occur.
  task automatic run_phase(input int n_items, input int idle, input int stall,
                           input bit overfill_first);
    int     sent;
    int     len;
    int     i;
    int     base;
    mix_t   mix;
    rm_in_t t;
    sent      = 0;
    idle_pct  = idle;
    stall_pct = stall;
    while (sent < n_items) begin
      if (overfill_first && sent == 0) begin
        // falling values: every insert shifts the whole store
        len = CAPACITY + 2;
        mix = MIX_FALLING;
      end else begin
        len = ($urandom_range(99) < 20) ? $urandom_range(CAPACITY + 8, CAPACITY - 4)
                                        : $urandom_range(24, 1);
        mix = mix_t'($urandom_range(3));
      end
      base = $urandom;
      for (i = 0; i < len; i++) begin
        case (mix)
          MIX_FULL:    t.sample = $urandom;
          MIX_NARROW:  t.sample = int'($urandom_range(16)) - 8;  // many ties
          MIX_EXTREME: begin
            case ($urandom_range(5))
              0:       t.sample = S_MIN;
              1:       t.sample = S_MAX;
              2:       t.sample = 0;
              3:       t.sample = -1;
              4:       t.sample = S_MIN + 1;
              default: t.sample = S_MAX - 1;
            endcase
          end
          default:     t.sample = base - i * 7;
        endcase
        t.last_sample = (i == len - 1);
        push_sample(t, 1'b0, '0);
        sent++;
      end
      seq_cnt++;
    end
  endtask

  initial begin : stimulus
    rm_in_t  t;
    rm_out_t res;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      t.sample         = dir_rows[i].sample;
      t.last_sample    = dir_rows[i].last;
      res.median       = dir_rows[i].med;
      res.sample_count = 7'(dir_rows[i].cnt);
      res.overflow     = dir_rows[i].ovf;
      push_sample(t, dir_rows[i].fixed, res);
    end

    // back-to-back, then sender gaps, then receiver stalls, then both
    run_phase(PHASE_ITEMS, 0,  0,  1'b1);
    run_phase(PHASE_ITEMS, 67, 0,  1'b0);
    run_phase(PHASE_ITEMS, 0,  67, 1'b0);
    run_phase(PHASE_ITEMS, 31, 31, 1'b0);
    in_valid <= 1'b0;

    while (pending_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d samples in %0d random sequences plus the directed rows",
             items_sent, seq_cnt);
    $display("checked %0d medians, %0d of them on a full store", results_seen, drops_seen);
    if (err_cnt == 0 && pending_medians.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/rm_pkg.sv
hw/rtl/rm_ctrl.sv
hw/rtl/rm_datapath.sv
hw/rtl/running_median.sv
tb/tb_top.sv
